// ===== rtl/bbec_pkg.sv =====
// ----------------------------------------------------------------------------
// bbec_pkg
// Shared constants, types and helper functions for the 3x3 edge-clipped box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bbec_pkg;

    // Geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int OUT_COL_W  = 10;

    // Configuration port
    localparam int IW_W      = 11;
    localparam int IH_W      = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam logic [IW_W-1:0]      IW_RESET         = 11'd1024;
    localparam logic [IH_W-1:0]      IH_RESET         = 13'd768;

    // Pixel and arithmetic widths
    localparam int CH_W     = 8;
    localparam int N_CH     = 3;
    localparam int PIX_W    = CH_W * N_CH;
    localparam int SUM_W    = 12;            // nine 8-bit values
    localparam int CNT_W    = 4;             // divisor count, up to nine
    localparam int X_W      = SUM_W + 1;     // 2*sum + n
    localparam int RECIP_W  = 18;
    localparam int RECIP_SH = 18;
    localparam int PROD_W   = X_W + RECIP_W;

    // Queues
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // Command handed from the front end to the back end
    typedef struct packed {
        logic             is_drain;
        logic [PIX_W-1:0] px;
        logic [ROW_W-1:0] row;      // output row
        logic [COL_W-1:0] col;      // pixel column, or drain column
        logic [COL_W-1:0] lo;       // drain span
        logic [COL_W-1:0] hi;
        logic             bank;     // pixel: bank written; drain: bank of last row
        logic             emit_mid;
        logic             emit_end;
        logic             top_ok;
        logic             left_ok;
        logic             two_rows;
        logic             eoi;
    } cmd_t;

    // One result waiting at the output
    typedef struct packed {
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
        logic                 eoi;
    } res_t;

    // Effective width minus one, width clipped to 1..MAX_WIDTH
    function automatic logic [COL_W-1:0] eff_wm1(input logic [IW_W-1:0] iw);
        logic [31:0] v;
        v = 32'(iw);
        if (v == 32'd0)
            v = 32'd1;
        if (v > 32'(MAX_WIDTH))
            v = 32'(MAX_WIDTH);
        return COL_W'(v - 32'd1);
    endfunction

    // Effective height minus one, height clipped to 1..MAX_HEIGHT
    function automatic logic [ROW_W-1:0] eff_hm1(input logic [IH_W-1:0] ih);
        logic [31:0] v;
        v = 32'(ih);
        if (v == 32'd0)
            v = 32'd1;
        if (v > 32'(MAX_HEIGHT))
            v = 32'(MAX_HEIGHT);
        return ROW_W'(v - 32'd1);
    endfunction

    // ceil(2^18 / (2n)); exact floor((2s+n)/(2n)) for 2s+n below 2^13
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bbec_ram.sv =====
// ----------------------------------------------------------------------------
// bbec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbec_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/bbec_front.sv =====
// ----------------------------------------------------------------------------
// bbec_front
// Accepts pixels and drain ticks, tracks raster position and frame state,
// and queues one command per item that has work for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bbec_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          mode,
    input  wire logic [bbec_pkg::CH_W-1:0]     in_red,
    input  wire logic [bbec_pkg::CH_W-1:0]     in_green,
    input  wire logic [bbec_pkg::CH_W-1:0]     in_blue,
    input  wire logic [bbec_pkg::COL_W-1:0]    wm1,
    input  wire logic [bbec_pkg::ROW_W-1:0]    hm1,
    output bbec_pkg::cmd_t                     cmd_head,
    output logic                               cmd_valid,
    input  wire logic                          cmd_pop
);

    logic [bbec_pkg::ROW_W-1:0] row_reg, row_next;
    logic [bbec_pkg::COL_W-1:0] col_reg, col_next;
    logic [bbec_pkg::COL_W-1:0] dcol_reg, dcol_next;
    logic                       loaded_reg, loaded_next;
    logic                       fbank_reg, fbank_next;

    bbec_pkg::cmd_t             cq_reg [bbec_pkg::CQ_DEPTH];
    logic [bbec_pkg::CQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bbec_pkg::CQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bbec_pkg::CQ_AW:0]   count_reg, count_next;

    logic [bbec_pkg::ROW_W-1:0] r;
    logic [bbec_pkg::COL_W-1:0] c;
    logic                       row_end;
    logic                       d_last;
    logic                       take;
    logic                       cq_wr;
    bbec_pkg::cmd_t             cmd;

    assign full      = (count_reg == (bbec_pkg::CQ_AW + 1)'(bbec_pkg::CQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_head  = cq_reg[rd_ptr_reg];
    assign take      = push && !full;

    always_comb
    begin
        // a pixel while a frame waits to drain starts a new image
        r       = loaded_reg ? '0 : row_reg;
        c       = loaded_reg ? '0 : col_reg;
        row_end = (c >= wm1);
        d_last  = (dcol_reg >= wm1);

        cmd = '0;
        if (!mode)
        begin
            cmd.px       = {in_red, in_green, in_blue};
            cmd.row      = bbec_pkg::ROW_W'(r - 1'b1);
            cmd.col      = c;
            cmd.bank     = r[0];
            cmd.emit_mid = (r != '0) && (c != '0);
            cmd.emit_end = (r != '0) && row_end;
            cmd.top_ok   = (r >= bbec_pkg::ROW_W'(2));
            cmd.left_ok  = (c >= bbec_pkg::COL_W'(2));
        end
        else
        begin
            cmd.is_drain = 1'b1;
            cmd.row      = hm1;
            cmd.col      = dcol_reg;
            cmd.lo       = (dcol_reg != '0) ? bbec_pkg::COL_W'(dcol_reg - 1'b1) : dcol_reg;
            cmd.hi       = (dcol_reg < wm1) ? bbec_pkg::COL_W'(dcol_reg + 1'b1) : dcol_reg;
            cmd.bank     = fbank_reg;
            cmd.two_rows = (hm1 != '0);
            cmd.eoi      = d_last;
        end

        cq_wr = take && (!mode || loaded_reg);

        row_next    = row_reg;
        col_next    = col_reg;
        dcol_next   = dcol_reg;
        loaded_next = loaded_reg;
        fbank_next  = fbank_reg;
        if (take && !mode)
        begin
            loaded_next = 1'b0;
            dcol_next   = '0;
            if (row_end)
            begin
                col_next = '0;
                if (r >= hm1)
                begin
                    row_next    = '0;
                    loaded_next = 1'b1;
                    fbank_next  = r[0];
                end
                else
                begin
                    row_next = bbec_pkg::ROW_W'(r + 1'b1);
                end
            end
            else
            begin
                row_next = r;
                col_next = bbec_pkg::COL_W'(c + 1'b1);
            end
        end
        else if (take && loaded_reg)
        begin
            if (d_last)
            begin
                loaded_next = 1'b0;
                dcol_next   = '0;
            end
            else
            begin
                dcol_next = bbec_pkg::COL_W'(dcol_reg + 1'b1);
            end
        end

        wr_ptr_next = cq_wr ? bbec_pkg::CQ_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? bbec_pkg::CQ_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (cq_wr && !cmd_pop)
            count_next = (bbec_pkg::CQ_AW + 1)'(count_reg + 1'b1);
        else if (!cq_wr && cmd_pop)
            count_next = (bbec_pkg::CQ_AW + 1)'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            dcol_reg   <= '0;
            loaded_reg <= 1'b0;
            fbank_reg  <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            dcol_reg   <= dcol_next;
            loaded_reg <= loaded_next;
            fbank_reg  <= fbank_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cq_wr)
        begin
            cq_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bbec_back.sv =====
// ----------------------------------------------------------------------------
// bbec_back
// Executes queued commands: line store access, 3x3 window, neighbourhood
// sums, rounded division, and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bbec_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bbec_pkg::cmd_t                    cmd_head,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_pop,
    output logic                                   empty,
    input  wire logic                              pop,
    output bbec_pkg::res_t                         res_head
);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_LOAD  = 5'b00010,
        B_SUM   = 5'b00100,
        B_DIV   = 5'b01000,
        B_DRAIN = 5'b10000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic    sel_end_reg, sel_end_next;

    bbec_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [bbec_pkg::PIX_W-1:0]     win_reg  [3][3];
    logic [bbec_pkg::PIX_W-1:0]     win_next [3][3];
    logic [bbec_pkg::SUM_W-1:0]     sum_reg  [bbec_pkg::N_CH];
    logic [bbec_pkg::SUM_W-1:0]     sum_next [bbec_pkg::N_CH];
    logic [bbec_pkg::CNT_W-1:0]     n_reg, n_next;
    logic [bbec_pkg::COL_W-1:0]     x_reg, x_next;
    logic [bbec_pkg::ROW_W-1:0]     orow_reg, orow_next;
    logic [bbec_pkg::COL_W-1:0]     ocol_reg, ocol_next;
    logic                           last_reg, last_next;
    logic                           eoi_reg, eoi_next;

    // line store banks
    logic                           we0, we1;
    logic [bbec_pkg::COL_W-1:0]     waddr, raddr;
    logic [bbec_pkg::PIX_W-1:0]     rd0, rd1;

    // result queue
    bbec_pkg::res_t                 oq_reg [bbec_pkg::OQ_DEPTH];
    logic [bbec_pkg::OQ_AW-1:0]     oq_wr_reg, oq_rd_reg;
    logic [bbec_pkg::OQ_AW:0]       oq_cnt_reg;
    logic                           oq_full, oq_push, oq_take;
    bbec_pkg::res_t                 res;

    // sum helpers
    logic [bbec_pkg::SUM_W-1:0]     cs [3][bbec_pkg::N_CH];
    logic [bbec_pkg::SUM_W-1:0]     mid_sum [bbec_pkg::N_CH];
    logic [bbec_pkg::SUM_W-1:0]     end_sum [bbec_pkg::N_CH];
    logic [bbec_pkg::CNT_W-1:0]     nrows, ncols_mid, ncols_end;
    logic [bbec_pkg::PIX_W-1:0]     fb, ob;
    logic [bbec_pkg::X_W-1:0]       xk;
    logic [bbec_pkg::PROD_W-1:0]    prod;
    logic [bbec_pkg::CH_W-1:0]      q [bbec_pkg::N_CH];

    bbec_ram #(
        .WIDTH (bbec_pkg::PIX_W),
        .DEPTH (bbec_pkg::MAX_WIDTH)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (we0),
        .wr_addr (waddr),
        .wr_data (cmd_reg.px),
        .rd_addr (raddr),
        .rd_data (rd0)
    );

    bbec_ram #(
        .WIDTH (bbec_pkg::PIX_W),
        .DEPTH (bbec_pkg::MAX_WIDTH)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (we1),
        .wr_addr (waddr),
        .wr_data (cmd_reg.px),
        .rd_addr (raddr),
        .rd_data (rd1)
    );

    assign oq_full  = (oq_cnt_reg == (bbec_pkg::OQ_AW + 1)'(bbec_pkg::OQ_DEPTH));
    assign empty    = (oq_cnt_reg == '0);
    assign oq_take  = pop && !empty;
    assign res_head = oq_reg[oq_rd_reg];
    assign waddr    = cmd_reg.col;

    // column sums of the window and the two neighbourhood sums
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < bbec_pkg::N_CH; k++)
            begin
                cs[j][k] = bbec_pkg::SUM_W'(win_reg[1][j][bbec_pkg::PIX_W-1-bbec_pkg::CH_W*k -:
                                                         bbec_pkg::CH_W])
                         + bbec_pkg::SUM_W'(win_reg[2][j][bbec_pkg::PIX_W-1-bbec_pkg::CH_W*k -:
                                                         bbec_pkg::CH_W]);
                if (cmd_reg.top_ok)
                    cs[j][k] = cs[j][k]
                             + bbec_pkg::SUM_W'(win_reg[0][j][bbec_pkg::PIX_W-1-bbec_pkg::CH_W*k -:
                                                             bbec_pkg::CH_W]);
            end
        end
        for (int k = 0; k < bbec_pkg::N_CH; k++)
        begin
            mid_sum[k] = cs[1][k] + cs[2][k] + (cmd_reg.left_ok ? cs[0][k] : '0);
            end_sum[k] = cs[2][k] + ((cmd_reg.col != '0) ? cs[1][k] : '0);
        end
        nrows     = cmd_reg.top_ok ? bbec_pkg::CNT_W'(3) : bbec_pkg::CNT_W'(2);
        ncols_mid = cmd_reg.left_ok ? bbec_pkg::CNT_W'(3) : bbec_pkg::CNT_W'(2);
        ncols_end = (cmd_reg.col != '0) ? bbec_pkg::CNT_W'(2) : bbec_pkg::CNT_W'(1);
    end

    // rounded division: floor((2s+n)/(2n)) by reciprocal multiply
    always_comb
    begin
        xk   = '0;
        prod = '0;
        for (int k = 0; k < bbec_pkg::N_CH; k++)
        begin
            xk   = bbec_pkg::X_W'({sum_reg[k], 1'b0}) + bbec_pkg::X_W'(n_reg);
            prod = bbec_pkg::PROD_W'(xk) * bbec_pkg::PROD_W'(bbec_pkg::recip(n_reg));
            q[k] = prod[bbec_pkg::RECIP_SH +: bbec_pkg::CH_W];
        end
        res.red   = q[0];
        res.green = q[1];
        res.blue  = q[2];
        res.row   = orow_reg;
        res.col   = bbec_pkg::OUT_COL_W'(ocol_reg);
        res.last  = last_reg;
        res.eoi   = eoi_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        sel_end_next = sel_end_reg;
        cmd_next     = cmd_reg;
        win_next     = win_reg;
        sum_next     = sum_reg;
        n_next       = n_reg;
        x_next       = x_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        last_next    = last_reg;
        eoi_next     = eoi_reg;
        cmd_pop      = 1'b0;
        oq_push      = 1'b0;
        we0          = 1'b0;
        we1          = 1'b0;
        raddr        = x_reg;
        fb           = cmd_reg.bank ? rd1 : rd0;
        ob           = cmd_reg.bank ? rd0 : rd1;

        unique case (state_reg)
            B_IDLE:
            begin
                raddr = cmd_head.is_drain ? cmd_head.lo : cmd_head.col;
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_head;
                    if (cmd_head.is_drain)
                    begin
                        sum_next   = '{default: '0};
                        n_next     = '0;
                        x_next     = cmd_head.lo;
                        orow_next  = cmd_head.row;
                        ocol_next  = cmd_head.col;
                        last_next  = 1'b1;
                        eoi_next   = cmd_head.eoi;
                        state_next = B_DRAIN;
                    end
                    else
                    begin
                        state_next = B_LOAD;
                    end
                end
            end

            B_LOAD:
            begin
                // fb: row two above (top), ob: row above (middle)
                for (int i = 0; i < 3; i++)
                begin
                    win_next[i][0] = win_reg[i][1];
                    win_next[i][1] = win_reg[i][2];
                end
                win_next[0][2] = fb;
                win_next[1][2] = ob;
                win_next[2][2] = cmd_reg.px;
                we0            = !cmd_reg.bank;
                we1            = cmd_reg.bank;
                sel_end_next   = !cmd_reg.emit_mid;
                state_next     = (cmd_reg.emit_mid || cmd_reg.emit_end) ? B_SUM : B_IDLE;
            end

            B_SUM:
            begin
                sum_next   = sel_end_reg ? end_sum : mid_sum;
                n_next     = bbec_pkg::CNT_W'(nrows * (sel_end_reg ? ncols_end : ncols_mid));
                orow_next  = cmd_reg.row;
                ocol_next  = sel_end_reg ? cmd_reg.col
                                         : bbec_pkg::COL_W'(cmd_reg.col - 1'b1);
                last_next  = sel_end_reg || !cmd_reg.emit_end;
                eoi_next   = 1'b0;
                state_next = B_DIV;
            end

            B_DIV:
            begin
                if (!oq_full)
                begin
                    oq_push = 1'b1;
                    if (!cmd_reg.is_drain && !sel_end_reg && cmd_reg.emit_end)
                    begin
                        sel_end_next = 1'b1;
                        state_next   = B_SUM;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end

            B_DRAIN:
            begin
                raddr = bbec_pkg::COL_W'(x_reg + 1'b1);
                for (int k = 0; k < bbec_pkg::N_CH; k++)
                begin
                    sum_next[k] = sum_reg[k]
                                + bbec_pkg::SUM_W'(fb[bbec_pkg::PIX_W-1-bbec_pkg::CH_W*k -:
                                                      bbec_pkg::CH_W])
                                + (cmd_reg.two_rows
                                   ? bbec_pkg::SUM_W'(ob[bbec_pkg::PIX_W-1-bbec_pkg::CH_W*k -:
                                                         bbec_pkg::CH_W])
                                   : '0);
                end
                n_next = bbec_pkg::CNT_W'(n_reg + (cmd_reg.two_rows ? 2'd2 : 2'd1));
                if (x_reg == cmd_reg.hi)
                    state_next = B_DIV;
                else
                    x_next = bbec_pkg::COL_W'(x_reg + 1'b1);
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            sel_end_reg <= 1'b0;
            oq_wr_reg   <= '0;
            oq_rd_reg   <= '0;
            oq_cnt_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_end_reg <= sel_end_next;
            if (oq_push)
                oq_wr_reg <= bbec_pkg::OQ_AW'(oq_wr_reg + 1'b1);
            if (oq_take)
                oq_rd_reg <= bbec_pkg::OQ_AW'(oq_rd_reg + 1'b1);
            if (oq_push && !oq_take)
                oq_cnt_reg <= (bbec_pkg::OQ_AW + 1)'(oq_cnt_reg + 1'b1);
            else if (!oq_push && oq_take)
                oq_cnt_reg <= (bbec_pkg::OQ_AW + 1)'(oq_cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        win_reg  <= win_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        x_reg    <= x_next;
        orow_reg <= orow_next;
        ocol_reg <= ocol_next;
        last_reg <= last_next;
        eoi_reg  <= eoi_next;
        if (oq_push)
            oq_reg[oq_wr_reg] <= res;
    end

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_edge_clipped.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped
// Streaming 3x3 box blur on RGB pixels, neighbours outside the image left out.
// ----------------------------------------------------------------------------
// Pixels enter in raster order through a push/full queue port; each pixel at
// row r, column c yields the rounded-half-up average for row r-1, column c-1,
// and the last pixel of a row also yields its column W-1. Once the last pixel
// of an image is in, each drain tick (mode 1) yields one pixel of the final
// row; end_of_image marks the bottom right one. The front end takes one item
// per cycle until its four-entry command queue is full. The back end works
// one command at a time: a pixel steps through IDLE, LOAD, then SUM and DIV
// per result; a drain tick through IDLE, a DRAIN step per neighbourhood
// column and DIV, since each line store bank is read once per cycle.
// Results wait in a two-entry queue. Line stores need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_edge_clipped (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              mode,
    input  wire logic [bbec_pkg::CH_W-1:0]         in_red,
    input  wire logic [bbec_pkg::CH_W-1:0]         in_green,
    input  wire logic [bbec_pkg::CH_W-1:0]         in_blue,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic      [bbec_pkg::CH_W-1:0]         out_red,
    output logic      [bbec_pkg::CH_W-1:0]         out_green,
    output logic      [bbec_pkg::CH_W-1:0]         out_blue,
    output logic      [bbec_pkg::ROW_W-1:0]        out_row,
    output logic      [bbec_pkg::OUT_COL_W-1:0]    out_col,
    output logic                                   last_in_run,
    output logic                                   end_of_image,
    input  wire logic                              cfg_write,
    input  wire logic [bbec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bbec_pkg::CFG_W-1:0]        cfg_data
);

    logic [bbec_pkg::IW_W-1:0]  image_width_reg;
    logic [bbec_pkg::IH_W-1:0]  image_height_reg;
    logic [bbec_pkg::COL_W-1:0] wm1;
    logic [bbec_pkg::ROW_W-1:0] hm1;

    bbec_pkg::cmd_t             cmd_head;
    logic                       cmd_valid;
    logic                       cmd_pop;
    bbec_pkg::res_t             res_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bbec_pkg::IW_RESET;
            image_height_reg <= bbec_pkg::IH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bbec_pkg::REG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg_data[bbec_pkg::IW_W-1:0];
                end
                bbec_pkg::REG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= cfg_data[bbec_pkg::IH_W-1:0];
                end
                default:
                begin
                    image_width_reg <= image_width_reg;
                end
            endcase
        end
    end

    assign wm1 = bbec_pkg::eff_wm1(image_width_reg);
    assign hm1 = bbec_pkg::eff_hm1(image_height_reg);

    bbec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .wm1       (wm1),
        .hm1       (hm1),
        .cmd_head  (cmd_head),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    bbec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_head  (cmd_head),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .res_head  (res_head)
    );

    assign out_red      = res_head.red;
    assign out_green    = res_head.green;
    assign out_blue     = res_head.blue;
    assign out_row      = res_head.row;
    assign out_col      = res_head.col;
    assign last_in_run  = res_head.last;
    assign end_of_image = res_head.eoi;

endmodule

`default_nettype wire

// ===== bench/box_blur_3x3_edge_clipped_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_test
// Self-checking bench for the streaming 3x3 edge-clipped box blur.
// ----------------------------------------------------------------------------
// A short table of directed pixels, drain ticks and register writes runs
// first. Random images follow: small frames with random, saturated, grey or
// near-extreme colours, zero register values that clip to one, noise drain
// ticks and drains cut short by the next image. Each accepted transaction
// runs through a local blur model; results are compared field by field with
// the oldest prediction. Sender gaps and receiver stalls change from phase
// to phase.
// ----------------------------------------------------------------------------

module box_blur_3x3_edge_clipped_test;

    localparam int PIX_W      = bbec_pkg::PIX_W;
    localparam int CH_W       = bbec_pkg::CH_W;
    localparam int ROW_W      = bbec_pkg::ROW_W;
    localparam int OUT_COL_W  = bbec_pkg::OUT_COL_W;
    localparam int CFG_W      = bbec_pkg::CFG_W;
    localparam int CFG_IDX_W  = bbec_pkg::CFG_IDX_W;
    localparam int IW_W       = bbec_pkg::IW_W;
    localparam int IH_W       = bbec_pkg::IH_W;
    localparam int MAX_WIDTH  = bbec_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = bbec_pkg::MAX_HEIGHT;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = bbec_pkg::REG_IMAGE_WIDTH;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = bbec_pkg::REG_IMAGE_HEIGHT;
    localparam logic [IW_W-1:0]      IW_RESET         = bbec_pkg::IW_RESET;
    localparam logic [IH_W-1:0]      IH_RESET         = bbec_pkg::IH_RESET;

    typedef bbec_pkg::res_t res_t;

    localparam int SETTLE          = 64;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int MAX_REPORTS     = 200;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [1:0] {STEP_PIXEL, STEP_DRAIN, STEP_CONFIG} step_kind_t;

    typedef struct {
        step_kind_t           kind;
        logic [PIX_W-1:0]     data;      // colour, or register value
        logic [CFG_IDX_W-1:0] reg_idx;
        int                   typed;     // results typed below; -1: take the blur model
        res_t                 want [2];
    } plan_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic                    mode = MODE_PIXEL;
    logic [CH_W-1:0]         in_red = '0;
    logic [CH_W-1:0]         in_green = '0;
    logic [CH_W-1:0]         in_blue = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [CH_W-1:0]         out_red;
    logic [CH_W-1:0]         out_green;
    logic [CH_W-1:0]         out_blue;
    logic [ROW_W-1:0]        out_row;
    logic [OUT_COL_W-1:0]    out_col;
    logic                    last_in_run;
    logic                    end_of_image;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]        cfg_data = '0;

    // blur model state
    logic [PIX_W-1:0] line_mem [0:2*MAX_WIDTH-1];
    logic [PIX_W-1:0] win [0:2][0:2];
    int               at_row = 0;
    int               at_col = 0;
    int               drain_pos = 0;
    bit               loaded = 1'b0;
    int               last_bank = 0;
    logic [IW_W-1:0]  cfg_width = IW_RESET;
    logic [IH_W-1:0]  cfg_height = IH_RESET;
    int               acc_r, acc_g, acc_b, acc_n;

    res_t      fresh [$];
    res_t      expected_px [$];
    plan_row_t steps [$];

    int send_idle = 0;
    int recv_stall = 0;
    int fail_count = 0;
    int cycle_count = 0;

    box_blur_3x3_edge_clipped u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .empty        (empty),
        .pop          (pop),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_in_run  (last_in_run),
        .end_of_image (end_of_image),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding", $time, expected_px.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Blur model
    // ------------------------------------------------------------------------
    function automatic int active_width();
        int v;
        v = int'(cfg_width);
        if (v < 1)
            v = 1;
        if (v > MAX_WIDTH)
            v = MAX_WIDTH;
        return v;
    endfunction

    function automatic int active_height();
        int v;
        v = int'(cfg_height);
        if (v < 1)
            v = 1;
        if (v > MAX_HEIGHT)
            v = MAX_HEIGHT;
        return v;
    endfunction

    function automatic void add_rgb(logic [PIX_W-1:0] px);
        acc_r += int'(px[23:16]);
        acc_g += int'(px[15:8]);
        acc_b += int'(px[7:0]);
        acc_n += 1;
    endfunction

    // half-up rounding: (2*sum + n) / (2*n)
    function automatic res_t average_out(int row, int col, bit eoi);
        res_t o;
        o.red   = CH_W'((2 * acc_r + acc_n) / (2 * acc_n));
        o.green = CH_W'((2 * acc_g + acc_n) / (2 * acc_n));
        o.blue  = CH_W'((2 * acc_b + acc_n) / (2 * acc_n));
        o.row   = ROW_W'(row);
        o.col   = OUT_COL_W'(col);
        o.last  = 1'b0;
        o.eoi   = eoi;
        return o;
    endfunction

    // window column cc with its neighbours, clipped at the image edges
    function automatic res_t window_avg(int cc, bit top_ok, bit left_ok, bit right_ok,
                                        int row, int col);
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        acc_n = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (i == 0 && !top_ok)
                continue;
            for (int j = cc - 1; j <= cc + 1; j++)
            begin
                if ((j < cc && !left_ok) || (j > cc && !right_ok) || j < 0 || j > 2)
                    continue;
                add_rgb(win[i][j]);
            end
        end
        return average_out(row, col, 1'b0);
    endfunction

    task automatic blur_step(input logic m, input logic [PIX_W-1:0] px);
        int   w, h, r, c, ci, bank, d, lo, hi, bk;
        bit   row_end;
        res_t o;
        w = active_width();
        h = active_height();
        fresh.delete();
        if (m == MODE_PIXEL)
        begin
            // a pixel during a pending drain starts a fresh image
            if (loaded)
            begin
                loaded = 1'b0;
                drain_pos = 0;
                at_row = 0;
                at_col = 0;
            end
            r = at_row;
            c = at_col;
            ci = c < MAX_WIDTH ? c : MAX_WIDTH - 1;
            bank = r & 1;
            for (int i = 0; i < 3; i++)
            begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = line_mem[bank * MAX_WIDTH + ci];
            win[1][2] = line_mem[(bank ^ 1) * MAX_WIDTH + ci];
            win[2][2] = px;
            line_mem[bank * MAX_WIDTH + ci] = px;
            row_end = c >= w - 1;
            if (r >= 1)
            begin
                if (c >= 1)
                    fresh.push_back(window_avg(1, r >= 2, c >= 2, 1'b1, r - 1, c - 1));
                if (row_end)
                    fresh.push_back(window_avg(2, r >= 2, c >= 1, 1'b0, r - 1, c));
            end
            if (row_end)
            begin
                at_col = 0;
                if (r >= h - 1)
                begin
                    at_row = 0;
                    loaded = 1'b1;
                    drain_pos = 0;
                    last_bank = bank;
                end
                else
                    at_row = r + 1;
            end
            else
                at_col = c + 1;
        end
        else if (loaded)
        begin
            d = drain_pos;
            lo = d >= 1 ? d - 1 : d;
            hi = d + 1 < w ? d + 1 : d;
            acc_r = 0;
            acc_g = 0;
            acc_b = 0;
            acc_n = 0;
            for (int b = 0; b < 2; b++)
            begin
                if (b == 1 && h < 2)
                    continue;
                bk = b == 0 ? last_bank : last_bank ^ 1;
                for (int x = lo; x <= hi; x++)
                    add_rgb(line_mem[bk * MAX_WIDTH + (x < MAX_WIDTH ? x : MAX_WIDTH - 1)]);
            end
            fresh.push_back(average_out(h - 1, d, d >= w - 1));
            if (d >= w - 1)
            begin
                loaded = 1'b0;
                drain_pos = 0;
            end
            else
                drain_pos = d + 1;
        end
        if (fresh.size() > 0)
        begin
            o = fresh.pop_back();
            o.last = 1'b1;
            fresh.push_back(o);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_item(input logic m, input logic [PIX_W-1:0] px, input bit use_model,
                             output int counts);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            mode <= 1'($urandom_range(0, 1));
            in_red <= CH_W'($urandom_range(0, 255));
            in_green <= CH_W'($urandom_range(0, 255));
            in_blue <= CH_W'($urandom_range(0, 255));
            @(posedge clk);
        end
        push <= 1'b1;
        mode <= m;
        in_red <= px[23:16];
        in_green <= px[15:8];
        in_blue <= px[7:0];
        @(posedge clk);
        while (full)
            @(posedge clk);
        counts = (m == MODE_PIXEL || loaded) ? 1 : 0;
        blur_step(m, px);
        if (use_model)
            foreach (fresh[i])
                expected_px.push_back(fresh[i]);
    endtask

    task automatic wait_quiet();
        push <= 1'b0;
        while (expected_px.size() != 0)
            @(posedge clk);
        // row-0 pixels and ignored drains leave nothing to wait on
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = IW_W'(val);
        else
            cfg_height = IH_W'(val);
    endtask

    task automatic run_image(input bit set_size, input int wv, input int hv,
                             output int tally_add);
        int               w, h, tone, stop, got;
        logic [PIX_W-1:0] px;
        tally_add = 0;
        if (set_size)
        begin
            // finish any pending drain so the new size never sees stale rows
            while (loaded)
            begin
                send_item(MODE_DRAIN, PIX_W'($urandom), 1'b1, got);
                tally_add += got;
            end
            write_reg(REG_IMAGE_WIDTH, wv);
            write_reg(REG_IMAGE_HEIGHT, hv);
        end
        else if ($urandom_range(0, 9) == 0)
            wait_quiet();
        w = active_width();
        h = active_height();
        tone = $urandom_range(0, 3);
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(MODE_DRAIN, PIX_W'($urandom), 1'b1, got);
                tally_add += got;
            end
            case (tone)
                0: px = PIX_W'($urandom);
                1: px = {{CH_W{1'($urandom_range(0, 1))}}, {CH_W{1'($urandom_range(0, 1))}},
                         {CH_W{1'($urandom_range(0, 1))}}};
                2: px = {CH_W'($urandom_range(0, 5) + 250 * $urandom_range(0, 1)),
                         CH_W'($urandom_range(0, 5) + 250 * $urandom_range(0, 1)),
                         CH_W'($urandom_range(0, 5) + 250 * $urandom_range(0, 1))};
                default: px = {3{CH_W'($urandom_range(0, 255))}};
            endcase
            send_item(MODE_PIXEL, px, 1'b1, got);
            tally_add += got;
        end
        // now and then the drain is cut short by the next image
        stop = $urandom_range(0, 4) == 0 ? $urandom_range(0, w - 1) : w;
        for (int i = 0; i < stop; i++)
        begin
            send_item(MODE_DRAIN, PIX_W'($urandom), 1'b1, got);
            tally_add += got;
        end
        if (stop == w)
            repeat ($urandom_range(0, 2))
                send_item(MODE_DRAIN, PIX_W'($urandom), 1'b1, got);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : take_result
        res_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_px.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result row %0d col %0d with nothing expected",
                                 $time, out_row, out_col);
                end
                else
                begin
                    want = expected_px.pop_front();
                    check_field("out_red", 12'(want.red), 12'(out_red));
                    check_field("out_green", 12'(want.green), 12'(out_green));
                    check_field("out_blue", 12'(want.blue), 12'(out_blue));
                    check_field("out_row", 12'(want.row), 12'(out_row));
                    check_field("out_col", 12'(want.col), 12'(out_col));
                    check_field("last_in_run", 12'(want.last), 12'(last_in_run));
                    check_field("end_of_image", 12'(want.eoi), 12'(end_of_image));
                end
            end
            pop <= $urandom_range(0, 99) >= recv_stall;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    function automatic res_t px_out(int v, int row, int col, bit last, bit eoi);
        res_t o;
        o.red   = CH_W'(v);
        o.green = CH_W'(v);
        o.blue  = CH_W'(v);
        o.row   = ROW_W'(row);
        o.col   = OUT_COL_W'(col);
        o.last  = last;
        o.eoi   = eoi;
        return o;
    endfunction

    function automatic plan_row_t item_row(step_kind_t kind, logic [PIX_W-1:0] data, int typed,
                                           res_t w0, res_t w1);
        plan_row_t p;
        p.kind    = kind;
        p.data    = data;
        p.reg_idx = REG_IMAGE_WIDTH;
        p.typed   = typed;
        p.want[0] = w0;
        p.want[1] = w1;
        return p;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
        plan_row_t p;
        p = item_row(STEP_CONFIG, PIX_W'(val), 0, '0, '0);
        p.reg_idx = idx;
        return p;
    endfunction

    initial
    begin
        int got, wv, hv, tally;
        res_t none;
        none = '0;

        // 2x2 white frame: every average is 255
        steps.push_back(reg_row(REG_IMAGE_WIDTH, 2));
        steps.push_back(reg_row(REG_IMAGE_HEIGHT, 2));
        steps.push_back(item_row(STEP_DRAIN, 24'h000000, 0, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'hFFFFFF, 0, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'hFFFFFF, 0, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'hFFFFFF, 0, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'hFFFFFF, 2, px_out(255, 0, 0, 1'b0, 1'b0),
                                 px_out(255, 0, 1, 1'b1, 1'b0)));
        steps.push_back(item_row(STEP_DRAIN, 24'h000000, 1, px_out(255, 1, 0, 1'b1, 1'b0), none));
        steps.push_back(item_row(STEP_DRAIN, 24'h000000, 1, px_out(255, 1, 1, 1'b1, 1'b1), none));
        steps.push_back(item_row(STEP_DRAIN, 24'h000000, 0, none, none));
        // mixed frame, drain abandoned after one tick
        steps.push_back(item_row(STEP_PIXEL, 24'h000000, -1, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'hFF0080, -1, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'h010203, -1, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'h00FF7F, -1, none, none));
        steps.push_back(item_row(STEP_DRAIN, 24'hFFFFFF, -1, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'h000000, 0, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'hFFFFFF, -1, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'h000000, -1, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'h804020, -1, none, none));
        steps.push_back(item_row(STEP_DRAIN, 24'h000000, -1, none, none));
        steps.push_back(item_row(STEP_DRAIN, 24'h000000, -1, none, none));
        // single-column frame: column 0 gives the row end output
        steps.push_back(reg_row(REG_IMAGE_WIDTH, 1));
        steps.push_back(reg_row(REG_IMAGE_HEIGHT, 3));
        steps.push_back(item_row(STEP_PIXEL, 24'hFF00FF, -1, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'h00FF00, -1, none, none));
        steps.push_back(item_row(STEP_PIXEL, 24'hFFFFFF, -1, none, none));
        steps.push_back(item_row(STEP_DRAIN, 24'h000000, -1, none, none));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[k])
        begin
            if (steps[k].kind == STEP_CONFIG)
                write_reg(steps[k].reg_idx, int'(steps[k].data));
            else
            begin
                send_item(steps[k].kind == STEP_DRAIN ? MODE_DRAIN : MODE_PIXEL, steps[k].data,
                          steps[k].typed < 0, got);
                for (int t = 0; t < steps[k].typed; t++)
                    expected_px.push_back(steps[k].want[t]);
            end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 70;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 70;
                end
                default:
                begin
                    send_idle = 19;
                    recv_stall = 19;
                end
            endcase
            tally = 0;
            if (ph == 0)
            begin
                // zero register values clip to a single pixel image
                run_image(1'b1, 0, 0, got);
                tally += got;
            end
            while (tally < ITEMS_PER_PHASE)
            begin
                wv = $urandom_range(0, 7) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8);
                if ($urandom_range(0, 19) == 0)
                    wv = 0;
                hv = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 6);
                run_image(1'($urandom_range(0, 1)), wv, hv, got);
                tally += got;
            end
        end

        wait_quiet();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bbec_pkg.sv
rtl/bbec_ram.sv
rtl/bbec_front.sv
rtl/bbec_back.sv
rtl/box_blur_3x3_edge_clipped.sv
bench/box_blur_3x3_edge_clipped_test.sv
